@@ src/mi_pkg.sv @@
// ----------------------------------------------------------------------------
// mi_pkg
// shared types for the modular inverse block: control and status of the
// iterative divide and coefficient accumulate unit
// ----------------------------------------------------------------------------
package mi_pkg;

    typedef struct packed {
        logic start;
    } mi_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mi_div_stat_t;

endpackage

@@ src/mi_div_unit.sv @@
// ----------------------------------------------------------------------------
// mi_div_unit
// restoring divider, one quotient bit per cycle, msb first; each quotient
// bit also feeds a horner accumulator that builds quotient * multiplicand
// ----------------------------------------------------------------------------
module mi_div_unit
    import mi_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mi_div_ctrl_t  ctrl,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    input  logic [W-1:0]  mult,
    output mi_div_stat_t  stat,
    output logic [W-1:0]  remainder,
    output logic [W-1:0]  product
);

    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(W - 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [W:0]       rem_sh;
    logic [W:0]       rem_sub;
    logic             ge;

    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[W-1]};
        ge      = (rem_sh >= {1'b0, divisor});
        rem_sub = rem_sh - {1'b0, divisor};

        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (ctrl.start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            acc_next  = '0;
            cnt_next  = CNT_TOP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            acc_next = {acc_reg[W-2:0], 1'b0} + (ge ? mult : '0);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;
    assign product   = acc_reg;

endmodule

@@ src/modular_inverse.sv @@
// ----------------------------------------------------------------------------
// modular_inverse
// inverse of value modulo a configured modulus by the extended euclidean
// algorithm, one quotient step at a time through a shared divider
// ----------------------------------------------------------------------------
//  channel   ports                                    role
//  in        in_valid, in_ready, value                operand transaction
//  out       out_valid, out_ready, inverse            result transaction
//  cfg       modulus_wr_en, modulus_wr_data           modulus write, no wait
//
//  each euclid step runs one division on the bit-serial divider, so the
//  time an item takes grows with its number of steps. in_ready is high
//  only while no item is in work. the result waits in an output register;
//  a stalled out channel holds the next result back. reset sets the
//  modulus to 1.
// ----------------------------------------------------------------------------
module modular_inverse
    import mi_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OPERAND_WIDTH-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OPERAND_WIDTH-1:0] inverse,
    input  logic                     modulus_wr_en,
    input  logic [OPERAND_WIDTH-1:0] modulus_wr_data
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_DIV    = 6'b000100,
        S_UPDATE = 6'b001000,
        S_REDUCE = 6'b010000,
        S_FIX    = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [W-1:0]   modulus_reg;
    logic [W-1:0]   r_old_reg, r_old_next;
    logic [W-1:0]   r_cur_reg, r_cur_next;
    logic [W-1:0]   m_old_reg, m_old_next;
    logic [W-1:0]   m_cur_reg, m_cur_next;
    logic           neg_reg, neg_next;
    logic [W-1:0]   red_reg, red_next;
    logic [W-1:0]   inverse_reg, inverse_next;
    logic           out_valid_reg, out_valid_next;

    mi_div_ctrl_t   div_ctrl;
    mi_div_stat_t   div_stat;
    logic [W-1:0]   div_rem;
    logic [W-1:0]   div_prod;

    mi_div_unit #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (r_old_reg),
        .divisor   (r_cur_reg),
        .mult      (m_cur_reg),
        .stat      (div_stat),
        .remainder (div_rem),
        .product   (div_prod)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        r_old_next     = r_old_reg;
        r_cur_next     = r_cur_reg;
        m_old_next     = m_old_reg;
        m_cur_next     = m_cur_reg;
        neg_next       = neg_reg;
        red_next       = red_reg;
        inverse_next   = inverse_reg;
        out_valid_next = out_valid_reg;
        div_ctrl.start = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    r_old_next = value;
                    r_cur_next = modulus_reg;
                    m_old_next = W'(1);
                    m_cur_next = '0;
                    neg_next   = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (r_cur_reg == '0)
                begin
                    state_next = S_REDUCE;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                r_old_next = r_cur_reg;
                r_cur_next = div_rem;
                m_old_next = m_cur_reg;
                m_cur_next = m_old_reg + div_prod;
                neg_next   = !neg_reg;
                state_next = S_CHECK;
            end
            S_REDUCE:
            begin
                if (modulus_reg == '0)
                begin
                    red_next = '0;
                end
                else if (m_old_reg >= modulus_reg)
                begin
                    red_next = m_old_reg - modulus_reg;
                end
                else
                begin
                    red_next = m_old_reg;
                end
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (neg_reg && (red_reg != '0))
                    begin
                        inverse_next = modulus_reg - red_reg;
                    end
                    else
                    begin
                        inverse_next = red_reg;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (modulus_wr_en)
            begin
                modulus_reg <= modulus_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_old_reg   <= r_old_next;
        r_cur_reg   <= r_cur_next;
        m_old_reg   <= m_old_next;
        m_cur_reg   <= m_cur_next;
        neg_reg     <= neg_next;
        red_reg     <= red_next;
        inverse_reg <= inverse_next;
    end

    assign out_valid = out_valid_reg;
    assign inverse   = inverse_reg;

endmodule
